// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg - shared types and constants for the text console writer
// Field widths, operation codes, the command record passed from the front
// end to the back end, and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	localparam int OP_W   = 3;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int ATTR_W = 8;
	localparam int CHAR_W = 8;
	localparam int WORD_W = 16;

	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [ATTR_W-1:0] attr_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [OP_W-1:0]   op_t;

	// operation codes on the op port
	localparam op_t OP_PUT_DEF    = 3'd0;
	localparam op_t OP_PUT_COLOR  = 3'd1;
	localparam op_t OP_PUT_AT     = 3'd2;
	localparam op_t OP_BACKSPACE  = 3'd3;
	localparam op_t OP_SET_CURSOR = 3'd4;
	localparam op_t OP_CLEAR      = 3'd5;
	localparam op_t OP_READ       = 3'd6;

	localparam char_t NEWLINE_CHAR = 8'h0A;
	localparam word_t SPACE_MASK   = 16'h0020;
	localparam attr_t DATTR_RESET  = 8'h02;

	// command class decided by the front end
	typedef enum logic [2:0] {
		CK_PUT,
		CK_BACKSPACE,
		CK_SET,
		CK_CLEAR,
		CK_READ,
		CK_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic      at;        // put at a given position, cursor kept
		logic      in_range;  // pos_x/pos_y inside the screen
		attr_t     attr;
		char_t     ch;
		col_t      col;
		row_t      row;
		word_t     fill;      // clear word, space bit already set
	} cmd_t;

	typedef struct packed {
		word_t cell_word;
		col_t  col;
		row_t  row;
		logic  rejected;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front - item intake and classification
// Decodes each accepted item into a command record and holds up to two
// commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	// item side
	input  wire logic  push,
	output logic       full,
	input  wire op_t   op,
	input  wire char_t char_code,
	input  wire logic [3:0] foreground,
	input  wire logic [2:0] background,
	input  wire logic  blink,
	input  wire col_t  pos_x,
	input  wire row_t  pos_y,
	input  wire word_t fill_word,
	// settings and status
	input  wire attr_t dattr,
	input  wire logic  init_busy,
	// command side
	output logic       cmd_valid,
	input  wire logic  cmd_take,
	output cmd_t       cmd
);

	localparam logic [COL_W:0] COL_LIMIT = COLUMNS[COL_W:0];
	localparam logic [ROW_W:0] ROW_LIMIT = ROWS[ROW_W:0];

	cmd_t       cmd_in;
	cmd_t       q_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push_ok;
	logic       take_ok;

	// classify the incoming item
	always_comb begin
		cmd_in          = '0;
		cmd_in.kind     = CK_NOP;
		cmd_in.in_range = ({1'b0, pos_x} < COL_LIMIT) && ({1'b0, pos_y} < ROW_LIMIT);
		cmd_in.attr     = dattr;
		cmd_in.ch       = char_code;
		cmd_in.col      = pos_x;
		cmd_in.row      = pos_y;
		cmd_in.fill     = fill_word | SPACE_MASK;
		case (op)
			OP_PUT_DEF: begin
				cmd_in.kind = CK_PUT;
			end
			OP_PUT_COLOR: begin
				cmd_in.kind = CK_PUT;
				cmd_in.attr = {blink, background, foreground};
			end
			OP_PUT_AT: begin
				cmd_in.kind = CK_PUT;
				cmd_in.at   = 1'b1;
			end
			OP_BACKSPACE:  cmd_in.kind = CK_BACKSPACE;
			OP_SET_CURSOR: cmd_in.kind = CK_SET;
			OP_CLEAR:      cmd_in.kind = CK_CLEAR;
			OP_READ:       cmd_in.kind = CK_READ;
			default:       cmd_in.kind = CK_NOP;
		endcase
	end

	assign full      = (cnt_q == 2'd2) || init_busy;
	assign push_ok   = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign take_ok   = cmd_take && cmd_valid;
	assign cmd       = q_q[rp_q];

	// command queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push_ok) wp_q <= !wp_q;
			if (take_ok) rp_q <= !rp_q;
			case ({push_ok, take_ok})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// command queue storage
	always_ff @(posedge clk) begin
		if (push_ok) begin
			q_q[wp_q] <= cmd_in;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back - command execution
// Owns the cursor and the cell store. Runs one command at a time: single
// cell writes, reads, and store sweeps (reset clear, clear, scroll), then
// queues the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire attr_t dattr,
	// command side
	input  wire logic  cmd_valid,
	input  wire cmd_t  cmd,
	output logic       cmd_take,
	output logic       init_busy,
	// result side
	input  wire logic  pop,
	output logic       empty,
	output result_t    res
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int COPY_N = (ROWS - 1) * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);

	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_PUT,
		ST_BS,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {
		SW_ZERO,
		SW_CLEAR,
		SW_SCROLL
	} sweep_t;

	state_t  state_q;
	sweep_t  mode_q;
	addr_t   sc_q;
	word_t   fill_q;
	col_t    wcol_q;
	row_t    wrow_q;
	col_t    cur_col_q;
	row_t    cur_row_q;
	logic    at_q;
	attr_t   attr_q;
	char_t   ch_q;
	word_t   rd_word_q;
	logic    rej_q;
	// store write stage
	logic    wr_en_s1;
	addr_t   wr_addr_s1;
	word_t   wr_data_s1;
	logic    wr_ram_s1;

	addr_t   pos_addr;
	addr_t   ram_raddr;
	word_t   ram_rdata;
	word_t   ram_wdata;

	// put: next position
	logic    nl;
	logic    wrap;
	row_t    nrow;
	logic    scroll;
	col_t    nxt_col;
	row_t    nxt_row;
	// backspace: new cursor
	col_t    bs_col;
	row_t    bs_row;

	// result queue
	result_t    res_q [2];
	logic       rwp_q;
	logic       rrp_q;
	logic [1:0] rcnt_q;
	logic       res_push;
	logic       res_pop;

	// cell address of the working position
	assign pos_addr  = addr_t'(wrow_q) * addr_t'(COLUMNS) + addr_t'(wcol_q);
	assign ram_raddr = (state_q == ST_SWEEP) ? (sc_q + addr_t'(COLUMNS)) : pos_addr;
	assign ram_wdata = wr_ram_s1 ? ram_rdata : wr_data_s1;

	tcw_ram #(
		.WIDTH (WORD_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (wr_en_s1),
		.waddr (wr_addr_s1),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cmd_take  = (state_q == ST_IDLE);
	assign init_busy = (state_q == ST_SWEEP) && (mode_q == SW_ZERO);

	// advance after a put: newline or last column wraps, a wrap onto the last row scrolls
	always_comb begin
		nl      = (ch_q == NEWLINE_CHAR);
		wrap    = nl || (wcol_q == col_t'(COLUMNS - 1));
		nrow    = (wrow_q == row_t'(ROWS - 1)) ? '0 : wrow_q + row_t'(1);
		scroll  = wrap && (nrow == row_t'(ROWS - 1));
		nxt_col = wrap ? '0 : wcol_q + col_t'(1);
		nxt_row = wrap ? (scroll ? row_t'(ROWS - 2) : nrow) : wrow_q;
	end

	// backspace: step left, up a row from column zero, stay at the origin
	always_comb begin
		bs_col = cur_col_q;
		bs_row = cur_row_q;
		if (cur_col_q != '0) begin
			bs_col = cur_col_q - col_t'(1);
		end else if (cur_row_q != '0) begin
			bs_col = col_t'(COLUMNS - 1);
			bs_row = cur_row_q - row_t'(1);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SWEEP;
			mode_q     <= SW_ZERO;
			sc_q       <= '0;
			fill_q     <= '0;
			wcol_q     <= '0;
			wrow_q     <= '0;
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			at_q       <= 1'b0;
			attr_q     <= '0;
			ch_q       <= '0;
			rd_word_q  <= '0;
			rej_q      <= 1'b0;
			wr_en_s1   <= 1'b0;
			wr_addr_s1 <= '0;
			wr_data_s1 <= '0;
			wr_ram_s1  <= 1'b0;
		end else begin
			wr_en_s1  <= 1'b0;
			wr_ram_s1 <= 1'b0;
			case (state_q)
				// walk the whole store; scroll copies a row up, then fills
				ST_SWEEP: begin
					wr_en_s1   <= 1'b1;
					wr_addr_s1 <= sc_q;
					wr_data_s1 <= fill_q;
					wr_ram_s1  <= (mode_q == SW_SCROLL) && (sc_q < addr_t'(COPY_N));
					if (sc_q == addr_t'(CELLS - 1)) begin
						state_q <= (mode_q == SW_ZERO) ? ST_IDLE : ST_RESP;
					end else begin
						sc_q <= sc_q + addr_t'(1);
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						rd_word_q <= '0;
						rej_q     <= 1'b0;
						at_q      <= cmd.at;
						attr_q    <= cmd.attr;
						ch_q      <= cmd.ch;
						case (cmd.kind)
							CK_PUT: begin
								if (cmd.at && !cmd.in_range) begin
									state_q <= ST_RESP;
								end else begin
									wcol_q  <= cmd.at ? cmd.col : cur_col_q;
									wrow_q  <= cmd.at ? cmd.row : cur_row_q;
									state_q <= ST_PUT;
								end
							end
							CK_BACKSPACE: begin
								cur_col_q <= bs_col;
								cur_row_q <= bs_row;
								wcol_q    <= bs_col;
								wrow_q    <= bs_row;
								state_q   <= ST_BS;
							end
							CK_SET: begin
								if (cmd.in_range) begin
									cur_col_q <= cmd.col;
									cur_row_q <= cmd.row;
								end else begin
									rej_q <= 1'b1;
								end
								state_q <= ST_RESP;
							end
							CK_CLEAR: begin
								cur_col_q <= '0;
								cur_row_q <= '0;
								fill_q    <= cmd.fill;
								mode_q    <= SW_CLEAR;
								sc_q      <= '0;
								state_q   <= ST_SWEEP;
							end
							CK_READ: begin
								wcol_q  <= cmd.col;
								wrow_q  <= cmd.row;
								state_q <= cmd.in_range ? ST_RD_ADDR : ST_RESP;
							end
							default: state_q <= ST_RESP;
						endcase
					end
				end
				// one character write (none for a newline), then cursor advance unless put-at, and maybe scroll
				ST_PUT: begin
					if (!nl) begin
						wr_en_s1   <= 1'b1;
						wr_addr_s1 <= pos_addr;
						wr_data_s1 <= {attr_q, ch_q};
					end
					if (!at_q) begin
						cur_col_q <= nxt_col;
						cur_row_q <= nxt_row;
					end
					if (scroll) begin
						fill_q  <= {dattr, 8'h00};
						mode_q  <= SW_SCROLL;
						sc_q    <= '0;
						state_q <= ST_SWEEP;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_BS: begin
					wr_en_s1   <= 1'b1;
					wr_addr_s1 <= pos_addr;
					wr_data_s1 <= {dattr, 8'h00};
					state_q    <= ST_RESP;
				end
				ST_RD_ADDR: state_q <= ST_RD_DATA;
				ST_RD_DATA: begin
					rd_word_q <= ram_rdata;
					state_q   <= ST_RESP;
				end
				ST_RESP: begin
					if (res_push) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result queue
	assign res_push = (state_q == ST_RESP) && (rcnt_q != 2'd2);
	assign empty    = (rcnt_q == 2'd0);
	assign res_pop  = pop && !empty;
	assign res      = res_q[rrp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwp_q  <= 1'b0;
			rrp_q  <= 1'b0;
			rcnt_q <= 2'd0;
		end else begin
			if (res_push) rwp_q <= !rwp_q;
			if (res_pop)  rrp_q <= !rrp_q;
			case ({res_push, res_pop})
				2'b10:   rcnt_q <= rcnt_q + 2'd1;
				2'b01:   rcnt_q <= rcnt_q - 2'd1;
				default: rcnt_q <= rcnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[rwp_q] <= '{cell_word: rd_word_q, col: cur_col_q, row: cur_row_q,
				rejected: rej_q};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer - text console with cell store and cursor
// Queue-style item and result ports, one configuration register.
// ----------------------------------------------------------------------------
// A COLUMNS x ROWS store of 16-bit cells (attribute high byte, character low
// byte) with a cursor. Items go into a two-entry command queue and are run
// one at a time by the back end; each gives exactly one result item, held in
// a two-entry result queue. After reset the store is cleared to zero by a
// pass over its COLUMNS*ROWS cells (2000 at 80x25) while full stays high;
// configuration writes are taken at any time (cfg_ready is always high) but
// must only be issued while the console is idle. In the back end a read goes
// through the single registered read port of the cell RAM. A clear and a put
// that scrolls both walk the whole store one cell a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data,
	// items
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  op,
	input  wire logic [7:0]  char_code,
	input  wire logic [3:0]  foreground,
	input  wire logic [2:0]  background,
	input  wire logic        blink,
	input  wire logic [6:0]  pos_x,
	input  wire logic [4:0]  pos_y,
	input  wire logic [15:0] fill_word,
	// results
	output logic             empty,
	input  wire logic        pop,
	output logic [15:0]      cell_word,
	output logic [6:0]       cursor_col,
	output logic [4:0]       cursor_row,
	output logic             rejected
);

	localparam logic [COL_W:0] COL_LIMIT = COLUMNS[COL_W:0];
	localparam logic [ROW_W:0] ROW_LIMIT = ROWS[ROW_W:0];

	attr_t   dattr_q;
	logic    init_busy;
	logic    cmd_valid;
	logic    cmd_take;
	cmd_t    cmd;
	result_t res;

	// default attribute register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dattr_q <= DATTR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dattr_q <= cfg_data;
		end
	end

	tcw_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.char_code  (char_code),
		.foreground (foreground),
		.background (background),
		.blink      (blink),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.fill_word  (fill_word),
		.dattr      (dattr_q),
		.init_busy  (init_busy),
		.cmd_valid  (cmd_valid),
		.cmd_take   (cmd_take),
		.cmd        (cmd)
	);

	tcw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dattr     (dattr_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.init_busy (init_busy),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign cell_word  = res.cell_word;
	assign cursor_col = res.col;
	assign cursor_row = res.row;
	assign rejected   = res.rejected;

	// reported cursor always lies on the screen
	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (({1'b0, cursor_col} < COL_LIMIT) && ({1'b0, cursor_row} < ROW_LIMIT)))
		else $error("cursor outside the screen");

	// a rejected set cursor never carries cell data
	a_reject_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rejected) |-> (cell_word == '0))
		else $error("rejected item with nonzero cell word");

	// no intake and no command start during the reset clear pass
	a_init_blocks_intake: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> (full && !cmd_take))
		else $error("item or command taken during clear pass");

	// a command taken from the queue moves the back end out of idle
	a_take_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_take && cmd_valid && !push) |=> !cmd_take)
		else $error("back end did not leave idle after taking a command");

endmodule

`default_nettype wire
